// ===== rtl/agac_pkg.sv =====
// ----------------------------------------------------------------------------
// agac_pkg
// Shared types and constants of the affine gap alignment cost block.
// ----------------------------------------------------------------------------
`default_nettype none

package agac_pkg;

  localparam logic CMD_PATTERN = 1'b0;
  localparam logic CMD_TEXT    = 1'b1;

  localparam int INF_VAL  = 10000000;
  localparam int INF_BITS = 25;
  localparam int ROW_BITS = 32;
  localparam int CFG_BITS = 16;

  localparam int GAP_OPEN_RST   = 6;
  localparam int GAP_EXTEND_RST = 2;
  localparam int MATCH_RST      = 0;
  localparam int MISMATCH_RST   = 4;

  typedef enum logic [1:0] {
    CFG_GAP_OPEN   = 2'd0,
    CFG_GAP_EXTEND = 2'd1,
    CFG_MATCH      = 2'd2,
    CFG_MISMATCH   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic       command;
    logic [7:0] symbol;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] score_m;
    logic signed [31:0] score_d;
    logic signed [31:0] score_i;
  } out_item_t;

  typedef struct packed {
    logic signed [CFG_BITS-1:0] gap_extend;
    logic signed [CFG_BITS-1:0] match;
    logic signed [CFG_BITS-1:0] mismatch;
  } cost_t;

  typedef struct packed {
    logic       wr;
    logic [7:0] sym;
  } load_t;

  typedef struct packed {
    logic       valid;
    logic       first;
    logic       last;
    logic [7:0] sym;
  } wave_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/agac_cell.sv =====
// ----------------------------------------------------------------------------
// agac_cell
// One pattern column of the alignment array: holds a pattern symbol and the
// previous row's M and I costs, computes one row entry per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module agac_cell #(
  parameter int SB  = 32,
  parameter int CW  = 9,
  parameter int IDX = 1
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire logic signed [SB-1:0] oe_i,
  input  agac_pkg::cost_t          cost_i,
  input  wire logic [CW-1:0]       cnt_i,
  input  agac_pkg::load_t          load_i,
  input  wire logic [CW-1:0]       load_idx_i,
  input  agac_pkg::wave_ctl_t      ctl_i,
  input  wire logic signed [SB-1:0] left_m_i,
  input  wire logic signed [SB-1:0] left_del_i,
  input  wire logic signed [SB-1:0] left_ins_i,
  input  wire logic signed [SB-1:0] diag_i,
  input  wire logic signed [SB-1:0] border_i,
  output agac_pkg::wave_ctl_t      ctl_o,
  output logic signed [SB-1:0]     m_o,
  output logic signed [SB-1:0]     del_o,
  output logic signed [SB-1:0]     ins_o,
  output logic signed [SB-1:0]     diag_o,
  output logic signed [SB-1:0]     border_o
);
  import agac_pkg::*;

  localparam logic signed [SB-1:0] INF_S =
    (SB >= INF_BITS) ? SB'(INF_VAL) : {1'b0, {(SB-1){1'b1}}};

  function automatic logic signed [SB-1:0] sat_add(input logic signed [SB-1:0] a,
                                                   input logic signed [SB-1:0] b);
    logic signed [SB:0] s;
    s = (SB+1)'(a) + (SB+1)'(b);
    if (s[SB] != s[SB-1]) begin
      return s[SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
    end
    return s[SB-1:0];
  endfunction

  function automatic logic signed [SB-1:0] min2(input logic signed [SB-1:0] a,
                                                input logic signed [SB-1:0] b);
    return (a <= b) ? a : b;
  endfunction

  logic [7:0]           sym_q;
  logic signed [SB-1:0] m_q, i_q;
  wave_ctl_t            ctl_q;
  logic signed [SB-1:0] m_out_q, del_out_q, ins_out_q, diag_out_q, border_out_q;

  logic                 active;
  logic signed [SB-1:0] ext_x, match_x, mism_x;
  logic signed [SB-1:0] border, pm, pi, del, ins, sub, mm;

  always_comb begin
    active  = (cnt_i >= CW'(IDX));
    ext_x   = SB'(cost_i.gap_extend);
    match_x = SB'(cost_i.match);
    mism_x  = SB'(cost_i.mismatch);
    border  = sat_add(border_i, ext_x);
    pm      = ctl_i.first ? border : m_q;
    pi      = ctl_i.first ? INF_S : i_q;
    del     = min2(sat_add(left_m_i, oe_i), sat_add(left_del_i, ext_x));
    ins     = min2(sat_add(pm, oe_i), sat_add(pi, ext_x));
    sub     = (sym_q == ctl_i.sym) ? match_x : mism_x;
    mm      = min2(sat_add(diag_i, sub), min2(ins, del));
  end

  // pattern symbol and column state
  always_ff @(posedge clk_i) begin
    if (load_i.wr && (load_idx_i == CW'(IDX - 1))) begin
      sym_q <= load_i.sym;
    end
    if (ctl_i.valid && active) begin
      m_q <= mm;
      i_q <= ins;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  // inactive columns pass the row values through
  always_ff @(posedge clk_i) begin
    m_out_q      <= active ? mm  : left_m_i;
    del_out_q    <= active ? del : left_del_i;
    ins_out_q    <= active ? ins : left_ins_i;
    diag_out_q   <= pm;
    border_out_q <= border;
  end

  assign ctl_o    = ctl_q;
  assign m_o      = m_out_q;
  assign del_o    = del_out_q;
  assign ins_o    = ins_out_q;
  assign diag_o   = diag_out_q;
  assign border_o = border_out_q;

endmodule

`default_nettype wire

// ===== rtl/affine_gap_global_alignment_cost_top.sv =====
// ----------------------------------------------------------------------------
// affine_gap_global_alignment_cost_top
// Global alignment cost with affine gaps over a row of MAX_PATTERN cells. A
// pattern is loaded one symbol per item (command 0, last ends the load); each
// text item (command 1) then sweeps one DP row through the cells as a
// wavefront that moves one cell per cycle, so text items are taken one per
// cycle when not stalled. The result of a final text item passes the
// column-zero register and every cell's register before the output register
// shows it. A pattern item waits until no row is left in the cells, and a
// final text item waits until the previous result has been taken. Costs are
// saturated to SCORE_BITS and results to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module affine_gap_global_alignment_cost_top #(
  parameter int MAX_PATTERN = 256,
  parameter int SCORE_BITS  = 32
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  agac_pkg::cfg_idx_e   cfg_idx_i,
  input  wire logic [15:0]     cfg_data_i,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  agac_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output agac_pkg::out_item_t  out_item_o
);
  import agac_pkg::*;

  localparam int SB = SCORE_BITS;
  localparam int CW = $clog2(MAX_PATTERN + 1);
  localparam int WX = SB + 32;
  localparam int PW = ROW_BITS + CFG_BITS + 2;
  localparam logic signed [SB-1:0] INF_S =
    (SB >= INF_BITS) ? SB'(INF_VAL) : {1'b0, {(SB-1){1'b1}}};

  function automatic logic signed [SB-1:0] sat_add(input logic signed [SB-1:0] a,
                                                   input logic signed [SB-1:0] b);
    logic signed [SB:0] s;
    s = (SB+1)'(a) + (SB+1)'(b);
    if (s[SB] != s[SB-1]) begin
      return s[SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
    end
    return s[SB-1:0];
  endfunction

  function automatic logic signed [SB-1:0] sat_wide(input logic signed [PW-1:0] x);
    logic signed [PW-1:0] hi, lo;
    hi = PW'({1'b0, {(SB-1){1'b1}}});
    lo = ~hi;
    if (x > hi) begin
      return hi[SB-1:0];
    end
    if (x < lo) begin
      return lo[SB-1:0];
    end
    return x[SB-1:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SB-1:0] x);
    logic signed [WX-1:0] xe;
    xe = WX'(x);
    if (xe > WX'(32'sh7fff_ffff)) begin
      return 32'sh7fff_ffff;
    end
    if (xe < WX'(32'sh8000_0000)) begin
      return 32'sh8000_0000;
    end
    return xe[31:0];
  endfunction

  // configuration
  logic signed [15:0]   open_q, ext_q, match_q, mism_q;
  logic signed [15:0]   open_d, ext_d, match_d, mism_d;
  logic signed [SB-1:0] oe_q;
  cost_t                cost;

  always_comb begin
    open_d  = open_q;
    ext_d   = ext_q;
    match_d = match_q;
    mism_d  = mism_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GAP_OPEN:   open_d  = cfg_data_i;
        CFG_GAP_EXTEND: ext_d   = cfg_data_i;
        CFG_MATCH:      match_d = cfg_data_i;
        CFG_MISMATCH:   mism_d  = cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 16'(GAP_OPEN_RST);
      ext_q   <= 16'(GAP_EXTEND_RST);
      match_q <= 16'(MATCH_RST);
      mism_q  <= 16'(MISMATCH_RST);
      oe_q    <= SB'(GAP_OPEN_RST + GAP_EXTEND_RST);
    end else begin
      open_q  <= open_d;
      ext_q   <= ext_d;
      match_q <= match_d;
      mism_q  <= mism_d;
      oe_q    <= sat_add(SB'(open_d), SB'(ext_d));
    end
  end

  assign cost = '{gap_extend: ext_q, match: match_q, mismatch: mism_q};

  // front end: pattern load, row counter and column zero
  logic                  loading_q, loading_d, ready_q, ready_d, res_pend_q, res_pend_d;
  logic [CW-1:0]         cnt_q, cnt_d, drain_q, drain_d, base_cnt;
  logic [ROW_BITS-1:0]   row_q, row_d, row_nxt;
  logic signed [SB-1:0]  col0_q, col0_d, col0_new, open_x;
  logic signed [PW-1:0]  col0_wide;
  logic                  acc, pat_acc, txt_acc, first;
  load_t                 load;

  wave_ctl_t             ctl_w   [MAX_PATTERN+1];
  logic signed [SB-1:0]  m_w     [MAX_PATTERN+1];
  logic signed [SB-1:0]  del_w   [MAX_PATTERN+1];
  logic signed [SB-1:0]  ins_w   [MAX_PATTERN+1];
  logic signed [SB-1:0]  diag_w  [MAX_PATTERN+1];
  logic signed [SB-1:0]  bord_w  [MAX_PATTERN+1];

  wave_ctl_t             w0_ctl_q, w0_ctl_d;
  logic signed [SB-1:0]  w0_m_q, w0_diag_q, w0_b_q;

  always_comb begin
    in_stall_o = (in_item_i.command == CMD_PATTERN) ? (drain_q != '0)
                                                    : (in_item_i.last && res_pend_q);
    acc      = in_valid_i && !in_stall_o;
    pat_acc  = acc && (in_item_i.command == CMD_PATTERN);
    txt_acc  = acc && (in_item_i.command == CMD_TEXT) && ready_q && !loading_q;
    base_cnt = loading_q ? cnt_q : '0;
    load.wr  = pat_acc && (base_cnt < CW'(MAX_PATTERN));
    load.sym = in_item_i.symbol;

    open_x    = SB'(open_q);
    first     = (row_q == '0);
    row_nxt   = (row_q == '1) ? row_q : row_q + ROW_BITS'(1);
    col0_wide = PW'(open_q) + PW'($signed({1'b0, row_nxt})) * PW'(ext_q);
    col0_new  = sat_wide(col0_wide);

    cnt_d      = cnt_q;
    loading_d  = loading_q;
    ready_d    = ready_q;
    row_d      = row_q;
    col0_d     = col0_q;
    res_pend_d = res_pend_q;

    if (pat_acc) begin
      cnt_d     = load.wr ? base_cnt + CW'(1) : base_cnt;
      loading_d = !in_item_i.last;
      ready_d   = in_item_i.last;
      row_d     = '0;
    end
    if (txt_acc) begin
      col0_d = col0_new;
      if (in_item_i.last) begin
        row_d      = '0;
        res_pend_d = 1'b1;
      end else if (row_q != '1) begin
        row_d = row_q + ROW_BITS'(1);
      end
    end
    if (out_valid_o && !out_stall_i) begin
      res_pend_d = 1'b0;
    end

    if (txt_acc) begin
      drain_d = CW'(MAX_PATTERN);
    end else if (drain_q != '0) begin
      drain_d = drain_q - CW'(1);
    end else begin
      drain_d = drain_q;
    end

    w0_ctl_d.valid = txt_acc;
    w0_ctl_d.first = first;
    w0_ctl_d.last  = in_item_i.last;
    w0_ctl_d.sym   = in_item_i.symbol;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      loading_q  <= 1'b0;
      ready_q    <= 1'b0;
      row_q      <= '0;
      res_pend_q <= 1'b0;
      drain_q    <= '0;
      w0_ctl_q   <= '0;
    end else begin
      cnt_q      <= cnt_d;
      loading_q  <= loading_d;
      ready_q    <= ready_d;
      row_q      <= row_d;
      res_pend_q <= res_pend_d;
      drain_q    <= drain_d;
      w0_ctl_q   <= w0_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col0_q    <= col0_d;
    w0_m_q    <= col0_new;
    w0_diag_q <= first ? '0 : col0_q;
    w0_b_q    <= open_x;
  end

  assign ctl_w[0]  = w0_ctl_q;
  assign m_w[0]    = w0_m_q;
  assign del_w[0]  = INF_S;
  assign ins_w[0]  = w0_m_q;
  assign diag_w[0] = w0_diag_q;
  assign bord_w[0] = w0_b_q;

  // cell chain
  for (genvar g = 1; g <= MAX_PATTERN; g++) begin : g_cell
    agac_cell #(
      .SB (SB),
      .CW (CW),
      .IDX(g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .oe_i       (oe_q),
      .cost_i     (cost),
      .cnt_i      (cnt_q),
      .load_i     (load),
      .load_idx_i (base_cnt),
      .ctl_i      (ctl_w[g-1]),
      .left_m_i   (m_w[g-1]),
      .left_del_i (del_w[g-1]),
      .left_ins_i (ins_w[g-1]),
      .diag_i     (diag_w[g-1]),
      .border_i   (bord_w[g-1]),
      .ctl_o      (ctl_w[g]),
      .m_o        (m_w[g]),
      .del_o      (del_w[g]),
      .ins_o      (ins_w[g]),
      .diag_o     (diag_w[g]),
      .border_o   (bord_w[g])
    );
  end

  // result register
  logic      out_valid_q, out_valid_d, cap;
  out_item_t out_q;

  always_comb begin
    cap         = ctl_w[MAX_PATTERN].valid && ctl_w[MAX_PATTERN].last;
    out_valid_d = out_valid_q;
    if (cap) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap) begin
      out_q.score_m <= sat32(m_w[MAX_PATTERN]);
      out_q.score_d <= sat32(del_w[MAX_PATTERN]);
      out_q.score_i <= sat32(ins_w[MAX_PATTERN]);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_out_has_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> res_pend_q)
    else $error("result shown without a pending final row");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cap |-> !out_valid_q)
    else $error("final row reached the output register while it was full");

  a_load_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pat_acc |-> (drain_q == '0))
    else $error("pattern symbol taken while rows were in the cells");

  a_pend_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (txt_acc && in_item_i.last) |=> (res_pend_q && (row_q == '0)))
    else $error("final text item did not arm the result");

endmodule

`default_nettype wire
